FILE: hw/rtl/alarm_trigger_edge_latch_defines.svh
// ----------------------------------------------------------------------------
// Alarm trigger edge latch assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ALARM_TRIGGER_EDGE_LATCH_DEFINES_SVH
`define ALARM_TRIGGER_EDGE_LATCH_DEFINES_SVH

`ifndef SYNTHESIS

`define ATE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ATE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ATE_ASSERT_IMP(name, ante, cons, msg)

`define ATE_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/ate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm trigger edge latch package
// Beat types, field widths and reset constants shared by all modules.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int unsigned VecW         = 8;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned LowRunW      = 8;
  localparam int unsigned RearmW       = 8;
  localparam int unsigned NumInputsDef = 8;

  localparam logic [LowRunW-1:0] LowRunMax  = 8'd255;
  localparam logic [RearmW-1:0]  RearmReset = 8'd4;

  typedef struct packed {
    logic [VecW-1:0] inputs_now;
    logic            take_alarm;
    logic            take_return;
  } in_beat_t;

  typedef struct packed {
    logic [VecW-1:0]  cleared_mask;
    logic             alarm_found;
    logic [SlotW-1:0] alarm_slot;
    logic             return_found;
    logic [SlotW-1:0] return_slot;
  } out_beat_t;

endpackage

FILE: hw/rtl/alarm_trigger_edge_latch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm trigger edge latch
// A beat in the input register has its result registered once the output advances.
// Throughput: one beat per cycle unless stalled, set by the single scan stage.
// Reset clears all flags and low-run counters and sets rearm_q to four.
// The input register and the result register are both empty after reset.
// ----------------------------------------------------------------------------
module alarm_trigger_edge_latch
  import ate_pkg::*;
#(
  parameter int unsigned NumInputs = NumInputsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_beat_o,
  input  logic              cfg_we_i,
  input  logic [RearmW-1:0] cfg_data_i
);

  logic              in_valid_q;
  in_beat_t          in_beat_q;
  logic              out_valid_q;
  out_beat_t         out_beat_q;
  out_beat_t         result;
  logic [RearmW-1:0] rearm_q;
  logic              advance;
  logic              step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rearm_q <= RearmReset;
    end else if (cfg_we_i) begin
      rearm_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_beat_q <= in_beat_i;
    end
    if (step) begin
      out_beat_q <= result;
    end
  end

  ate_scan #(
    .NumInputs(NumInputs)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (step),
    .beat_i  (in_beat_q),
    .rearm_i (rearm_q),
    .result_o(result)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

FILE: hw/rtl/ate_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest set bit picker
// Isolates the lowest request, encodes its slot modulo eight and builds the
// mask of all positions up to and including it.
// ----------------------------------------------------------------------------
module ate_pick
  import ate_pkg::*;
#(
  parameter int unsigned Width = NumInputsDef
) (
  input  logic [Width-1:0] req_i,
  output logic             found_o,
  output logic [SlotW-1:0] slot_o,
  output logic [Width-1:0] upto_o
);

  logic [Width-1:0] lowest;

  assign lowest   = req_i & (~req_i + Width'(1));
  assign upto_o   = req_i ^ (req_i - Width'(1));
  assign found_o  = |req_i;

  always_comb begin
    slot_o = '0;
    for (int j = 0; j < int'(Width); j++) begin
      if (lowest[j]) begin
        slot_o = slot_o | SlotW'(j);
      end
    end
  end

endmodule

FILE: hw/rtl/ate_scan.sv
`timescale 1ns / 1ps
`include "alarm_trigger_edge_latch_defines.svh"
// ----------------------------------------------------------------------------
// Alarm trigger edge latch scan stage
// Holds the per-input flags and low-run counters, applies one scan tick and
// the optional alarm and return takes, and forms the result beat.
// ----------------------------------------------------------------------------
module ate_scan
  import ate_pkg::*;
#(
  parameter int unsigned NumInputs = NumInputsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  in_beat_t          beat_i,
  input  logic [RearmW-1:0] rearm_i,
  output out_beat_t         result_o
);

  logic [NumInputs-1:0] armed_q, armed_d;
  logic [NumInputs-1:0] pa_q, pa_d;
  logic [NumInputs-1:0] pr_q, pr_d;
  logic [LowRunW-1:0]   low_run_q [NumInputs];
  logic [LowRunW-1:0]   low_run_d [NumInputs];

  logic [NumInputs-1:0] lvl;
  logic [NumInputs-1:0] disarm;
  logic [NumInputs-1:0] arm_new;
  logic [NumInputs-1:0] pa_scan;
  logic [NumInputs-1:0] pr_scan;
  logic [NumInputs-1:0] hit;
  logic [VecW-1:0]      cleared;

  logic                 a_found, r_found;
  logic [SlotW-1:0]     a_slot, r_slot;
  logic [NumInputs-1:0] a_upto;
  logic [NumInputs-1:0] r_upto;

  for (genvar i = 0; i < NumInputs; i++) begin : g_lvl
    if (i < VecW) begin : g_in
      assign lvl[i] = beat_i.inputs_now[i];
    end else begin : g_low
      assign lvl[i] = 1'b0;
    end
  end

  for (genvar b = 0; b < VecW; b++) begin : g_clr
    if (b < NumInputs) begin : g_in
      assign cleared[b] = disarm[b];
    end else begin : g_none
      assign cleared[b] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(NumInputs); i++) begin
      if (lvl[i]) begin
        low_run_d[i] = '0;
      end else if (low_run_q[i] == LowRunMax) begin
        low_run_d[i] = LowRunMax;
      end else begin
        low_run_d[i] = low_run_q[i] + LowRunW'(1);
      end
      disarm[i]  = !lvl[i] && armed_q[i] && (low_run_d[i] >= rearm_i);
      arm_new[i] = lvl[i] && !armed_q[i] && !pa_q[i];
    end
  end

  assign armed_d = (armed_q & ~disarm) | arm_new;
  assign pa_scan = pa_q | arm_new;
  assign pr_scan = pr_q | disarm;
  assign hit     = pa_scan & lvl;

  ate_pick #(
    .Width(NumInputs)
  ) u_pick_alarm (
    .req_i   (hit),
    .found_o (a_found),
    .slot_o  (a_slot),
    .upto_o  (a_upto)
  );

  ate_pick #(
    .Width(NumInputs)
  ) u_pick_return (
    .req_i   (pr_scan),
    .found_o (r_found),
    .slot_o  (r_slot),
    .upto_o  (r_upto)
  );

  // A take drops every pending alarm up to the chosen one; those below it are low.
  assign pa_d = beat_i.take_alarm ? (pa_scan & ~a_upto) : pa_scan;
  assign pr_d = beat_i.take_return ? (pr_scan & ~r_upto) : pr_scan;

  always_comb begin
    result_o.cleared_mask = cleared;
    result_o.alarm_found  = beat_i.take_alarm && a_found;
    result_o.alarm_slot   = beat_i.take_alarm ? a_slot : '0;
    result_o.return_found = beat_i.take_return && r_found;
    result_o.return_slot  = beat_i.take_return ? r_slot : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      pa_q    <= '0;
      pr_q    <= '0;
      for (int i = 0; i < int'(NumInputs); i++) begin
        low_run_q[i] <= '0;
      end
    end else if (en_i) begin
      armed_q <= armed_d;
      pa_q    <= pa_d;
      pr_q    <= pr_d;
      for (int i = 0; i < int'(NumInputs); i++) begin
        low_run_q[i] <= low_run_d[i];
      end
    end
  end

  `ATE_ASSERT_IMP(a_disarm_armed, en_i, ((disarm & ~armed_q) == '0), "disarm of unarmed input")
  `ATE_ASSERT_IMP(a_arm_pending, en_i, ((arm_new & ~pa_scan) == '0), "arm without pending alarm")
  `ATE_ASSERT_NXT(a_return_kept, en_i && !beat_i.take_return, ((pr_q & $past(disarm)) == $past(disarm)), "return lost")
  `ATE_ASSERT_NXT(a_hold_idle, !en_i, $stable(armed_q) && $stable(pa_q) && $stable(pr_q), "state moved without scan")
  `ATE_ASSERT_IMP(a_alarm_high, en_i && result_o.alarm_found, ((hit & a_upto) != '0), "taken alarm not high")

endmodule
